// ===== src/dual_mode_range_prng_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual mode range PRNG
// Shared property forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef DUAL_MODE_RANGE_PRNG_DEFINES_SVH
`define DUAL_MODE_RANGE_PRNG_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define DMRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dmrp: same-cycle check failed");

// Next-cycle implication, off while reset is held
`define DMRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dmrp: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define DMRP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dmrp: reset check failed");

`endif

// ===== src/dmrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrp_pkg
// Constants, codes and control types shared by the PRNG modules.
// ----------------------------------------------------------------------------
package dmrp_pkg;

    localparam int STATE_W    = 64;
    localparam int VALUE_W    = 32;
    localparam int SPAN_W     = 31;
    localparam int CFG_DATA_W = 64;
    localparam int DIVISOR_W  = 33;
    localparam int DIV_CNT_W  = 6;
    localparam int XS_REM_W   = 35;
    localparam int XS_STAGES  = 5;

    localparam logic [31:0]          LCG_MUL    = 32'd19004983;
    localparam logic [31:0]          LCG_ADD    = 32'd19004989;
    localparam logic [DIVISOR_W-1:0] XS_MOD     = 33'd7837654853;
    localparam logic [XS_REM_W-1:0]  XS_MOD_EXT = {2'b00, XS_MOD};
    // floor(2^64 / XS_MOD): quotient estimate from the top 32 bits
    localparam logic [31:0]          XS_RECIP   = 32'((65'd1 << 64) / {32'd0, XS_MOD});
    localparam int                   XS_SH_A    = 11;
    localparam int                   XS_SH_B    = 13;
    localparam int                   XS_SH_C    = 7;
    localparam logic [STATE_W-1:0]   SEED_RESET = 64'd6089;
    localparam logic [SPAN_W-1:0]    SPAN_RESET = 31'd10000;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_SEED = 2'd1,
        CFG_MIN  = 2'd2,
        CFG_SPAN = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CSTART,
        S_CWAIT,
        S_SSTART,
        S_SWAIT,
        S_OUT
    } t_ctrl_state;

    typedef struct packed {
        logic step;
        logic xs_start;
        logic div_start;
        logic load_state_rem;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic xs_busy;
        logic div_busy;
    } t_dp_status;

endpackage

// ===== src/dmrp_draw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrp_draw_if
// Request channel: one draw tick per item.
// ----------------------------------------------------------------------------
interface dmrp_draw_if;
    logic valid;
    logic ready;
    logic draw;

    modport source (output valid, output draw, input ready);
    modport sink   (input valid, input draw, output ready);
endinterface

// ===== src/dmrp_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrp_result_if
// Result channel: one signed random value per item.
// ----------------------------------------------------------------------------
interface dmrp_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [dmrp_pkg::VALUE_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ===== src/dmrp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrp_div
// Restoring remainder unit: 64-bit dividend, 33-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module dmrp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [dmrp_pkg::STATE_W-1:0]    i_dividend,
    input  logic [dmrp_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                            o_busy,
    output logic [dmrp_pkg::DIVISOR_W-1:0]  o_rem
);
    import dmrp_pkg::*;

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [STATE_W-1:0]     r_dvd;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVISOR_W-1:0]   r_div;

    logic [DIVISOR_W:0]     w_shift;
    logic [DIVISOR_W:0]     w_sub;
    logic                   w_ge;
    logic [DIVISOR_W-1:0]   n_rem;

    always_comb begin
        w_shift = {r_rem, r_dvd[STATE_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_sub   = w_shift - {1'b0, r_div};
        // Below the divisor the shifted value fits the remainder width
        n_rem   = w_ge ? w_sub[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (&r_cnt) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[STATE_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

// ===== src/dmrp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrp_dp
// Datapath: config registers, generator state, step logic, fixed-modulus
// reduction, span remainder unit and the result register.
// ----------------------------------------------------------------------------
module dmrp_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  dmrp_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [dmrp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  dmrp_pkg::t_dp_cmd                i_cmd,
    output dmrp_pkg::t_dp_status             o_status,
    output logic [dmrp_pkg::VALUE_W-1:0]     o_random_value
);
    import dmrp_pkg::*;

    logic                   r_mode;
    logic [VALUE_W-1:0]     r_min;
    logic [SPAN_W-1:0]      r_span;
    logic [STATE_W-1:0]     r_state;
    logic [VALUE_W-1:0]     r_out;
    logic [XS_STAGES-1:0]   r_xs_stg;
    logic [STATE_W-1:0]     r_xs_prod;
    logic [XS_REM_W-1:0]    r_xs_qm;
    logic [XS_REM_W-1:0]    r_xs_rem;

    logic [31:0]            w_lcg;
    logic [STATE_W-1:0]     w_xs1;
    logic [STATE_W-1:0]     w_xs2;
    logic [STATE_W-1:0]     w_xs3;
    logic [STATE_W-1:0]     n_step;
    logic [XS_REM_W-1:0]    w_xs_qm;
    logic                   w_xs_busy;
    logic [DIVISOR_W-1:0]   w_xs_rem;
    logic [DIVISOR_W-1:0]   w_divisor;
    logic                   w_div_busy;
    logic [DIVISOR_W-1:0]   w_div_rem;
    logic [SPAN_W-1:0]      w_span_rem;

    always_comb begin
        w_lcg  = r_state[31:0] * LCG_MUL + LCG_ADD;
        w_xs1  = r_state ^ (r_state << XS_SH_A);
        w_xs2  = w_xs1 ^ (w_xs1 >> XS_SH_B);
        w_xs3  = w_xs2 ^ (w_xs2 << XS_SH_C);
        // Xorshift result still needs its modulo pass
        n_step = r_mode ? w_xs3 : {32'd0, w_lcg};
    end

    // Fixed modulus: estimate the quotient from the top word, take the low
    // bits of the difference, then trim with two compare-and-subtract steps
    assign w_xs_qm = {{(XS_REM_W-32){1'b0}}, r_xs_prod[STATE_W-1:32]} * XS_MOD_EXT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xs_stg <= '0;
        end else if (i_cmd.xs_start) begin
            r_xs_stg <= {{(XS_STAGES-1){1'b0}}, 1'b1};
        end else begin
            r_xs_stg <= {r_xs_stg[XS_STAGES-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_xs_stg[0]) begin
            r_xs_prod <= {32'd0, r_state[STATE_W-1:32]} * {32'd0, XS_RECIP};
        end
        if (r_xs_stg[1]) begin
            r_xs_qm <= w_xs_qm;
        end
        if (r_xs_stg[2]) begin
            r_xs_rem <= r_state[XS_REM_W-1:0] - r_xs_qm;
        end else if ((r_xs_stg[3] || r_xs_stg[4]) && (r_xs_rem >= XS_MOD_EXT)) begin
            r_xs_rem <= r_xs_rem - XS_MOD_EXT;
        end
    end

    assign w_xs_busy = |r_xs_stg;
    assign w_xs_rem  = r_xs_rem[DIVISOR_W-1:0];

    assign w_divisor = {2'b00, r_span};

    dmrp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_state),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_rem      (w_div_rem)
    );

    // A zero span gives a zero remainder
    assign w_span_rem = (r_span == '0) ? '0 : w_div_rem[SPAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_min   <= '0;
            r_span  <= SPAN_RESET;
            r_state <= SEED_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE: r_mode <= i_cfg_data[0];
                    CFG_SEED: r_state <= i_cfg_data;
                    CFG_MIN:  r_min <= i_cfg_data[VALUE_W-1:0];
                    CFG_SPAN: r_span <= i_cfg_data[SPAN_W-1:0];
                    default:  r_mode <= r_mode;
                endcase
            end else if (i_cmd.step) begin
                r_state <= n_step;
            end else if (i_cmd.load_state_rem) begin
                r_state <= {{(STATE_W-DIVISOR_W){1'b0}}, w_xs_rem};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_min + {1'b0, w_span_rem};
        end
    end

    assign o_status.mode     = r_mode;
    assign o_status.xs_busy  = w_xs_busy;
    assign o_status.div_busy = w_div_busy;
    assign o_random_value    = r_out;

endmodule

// ===== src/dmrp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrp_ctrl
// Sequencer: steps the generator, runs the remainder passes and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module dmrp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_draw,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  dmrp_pkg::t_dp_status  i_status,
    output dmrp_pkg::t_dp_cmd     o_cmd
);
    import dmrp_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                // An item without a draw tick is dropped
                if (i_in_valid && i_in_draw) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.mode ? S_CSTART : S_SSTART;
            end
            S_CSTART: begin
                o_cmd.xs_start = 1'b1;
                n_state        = S_CWAIT;
            end
            S_CWAIT: begin
                if (!i_status.xs_busy) begin
                    o_cmd.load_state_rem = 1'b1;
                    n_state              = S_SSTART;
                end
            end
            S_SSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_SWAIT;
            end
            S_SWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/dual_mode_range_prng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mode_range_prng
// Range-limited PRNG with congruential and xorshift-modulo generators.
// ----------------------------------------------------------------------------
// Usage:
//   i_draw carries one item per request; an item whose draw bit is 0 is
//   accepted and dropped, with no result. Each item with draw set gives one
//   item on o_result: min_value plus the new state modulo span.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data while idle;
//   writing the seed reloads the generator state.
//   The span remainder runs in the one-bit-a-cycle remainder unit; mode 1
//   first reduces the xorshift state by the fixed modulus in a 5-stage
//   reciprocal-multiply unit. One item is in work at a time, so a new item
//   is taken only once the last one is through; i_draw.ready returns high
//   once the result is in the output register.
//   Reset (synchronous, active low) restores mode 0, seed 6089, minimum 0
//   and span 10000, and empties the output register.
//   A stalled receiver holds the result in the output register; the next
//   item is still accepted and worked on, and waits at the end for the
//   register to free up.
// ----------------------------------------------------------------------------
module dual_mode_range_prng (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dmrp_draw_if.sink                        i_draw,
    dmrp_result_if.source                    o_result,
    input  logic                             i_cfg_we,
    input  dmrp_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [dmrp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dmrp_pkg::*;

    t_dp_cmd               w_cmd;
    t_dp_status            w_status;
    logic [VALUE_W-1:0]    w_random_value;

    dmrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_draw.valid),
        .i_in_draw   (i_draw.draw),
        .o_in_ready  (i_draw.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dmrp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_random_value (w_random_value)
    );

    assign o_result.random_value = w_random_value;

endmodule

// ===== src/dmrp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrp_chk
// Port-level checks on the PRNG channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_mode_range_prng_defines.svh"

module dmrp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_draw_valid,
    input logic                          i_draw_ready,
    input logic                          i_draw,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [dmrp_pkg::VALUE_W-1:0]  i_random_value
);

    // A draw tick starts work, so no further item is taken next cycle
    `DMRP_ASSERT_NEXT(a_busy_after_draw, i_clk, i_rst_n, i_draw_valid && i_draw_ready && i_draw, !i_draw_ready)
    // An item without a draw tick leaves the block idle
    `DMRP_ASSERT_NEXT(a_idle_after_nodraw, i_clk, i_rst_n, i_draw_valid && i_draw_ready && !i_draw, i_draw_ready)
    // Reset empties the output register
    `DMRP_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_res_valid)
    // Hold a stalled result
    `DMRP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_random_value))
    // Same-cycle form: two draw accepts never come back to back
    `DMRP_ASSERT_IMPLY(a_ready_idle, i_clk, i_rst_n, i_draw_ready && i_draw_valid && i_draw, !$past(i_draw_ready && i_draw_valid && i_draw))

endmodule

bind dual_mode_range_prng dmrp_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_draw_valid   (i_draw.valid),
    .i_draw_ready   (i_draw.ready),
    .i_draw         (i_draw.draw),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_random_value (o_result.random_value)
);

// ===== test/dual_mode_range_prng_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mode_range_prng_tb
// Self-checking bench for the dual mode range PRNG. A short directed table
// covers the reset values, range extremes, zero span, a zero seed and mode
// switches without reseeding. Random phases then reprogramme the registers
// and draw numbers under random idling on both sides. Every value is checked
// against a bit-accurate generator model kept in the bench, or a typed value.
// ----------------------------------------------------------------------------
module dual_mode_range_prng_tb;

    import dmrp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RST_CYCLES    = 10;
    localparam int ITEM_TARGET   = 1950;
    localparam int CALM_DRAWS    = 250;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 3000;
    localparam int LONG_HOLD     = 600;
    localparam int TIMEOUT_NS    = 20_000_000;

    localparam logic [31:0] LCG_FACTOR = 32'd19004983;
    localparam logic [31:0] LCG_OFFSET = 32'd19004989;
    localparam logic [63:0] XS_MODULUS = 64'd7837654853;

    typedef enum logic {
        ROW_CFG,
        ROW_DRAW
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [63:0] data;
        logic        tick;
        logic        typed;
        logic [31:0] value;
    } t_stim_row;

    localparam int DIR_ROWS = 35;

    // Typed values: reset defaults, span of one, zero span, zero seed
    localparam t_stim_row DIR_TABLE [0:DIR_ROWS-1] = '{
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b1, 32'd6780},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_MIN,  64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SPAN, 64'd1,                   1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b1, 32'h8000_0000},
        '{ROW_CFG,  CFG_MIN,  64'h0000_0000_7FFF_FFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SPAN, 64'h0000_0000_7FFF_FFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SPAN, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b1, 32'h7FFF_FFFF},
        '{ROW_CFG,  CFG_MIN,  64'd0,                   1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SPAN, 64'd10000,               1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_MODE, 64'd1,                   1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SEED, 64'd0,                   1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b1, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b1, 32'd0},
        '{ROW_CFG,  CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SPAN, 64'h0000_0000_7FFF_FFFF, 1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SEED, 64'd0,                   1'b0, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_SPAN, 64'd10000,               1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b1, 32'd4989},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_CFG,  CFG_MODE, 64'd3,                   1'b0, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0},
        '{ROW_DRAW, CFG_MODE, 64'd0,                   1'b1, 1'b0, 32'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dmrp_draw_if   draw_ch ();
    dmrp_result_if res_ch ();

    dual_mode_range_prng DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_draw     (draw_ch),
        .o_result   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Generator model and its registers
    logic        gen_mode;
    logic [63:0] gen_state;
    logic [31:0] range_min;
    logic [30:0] range_span;

    logic [31:0] drawn_values [$];

    bit idle_on;
    bit calm;
    bit hold_req;
    bit hold_taken;
    int hold_left;
    int stall_left;
    int n_draws;
    int n_ignored;
    int n_checked;
    int n_fail;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("dual_mode_range_prng_tb: errors");
        $finish;
    end

    // Advance the generator one step and return the ranged value
    function automatic logic [31:0] draw_next_value();
        logic [63:0] s;
        logic [31:0] lo;
        logic [63:0] rem;
        s = gen_state;
        if (gen_mode == 1'b0) begin
            lo = s[31:0] * LCG_FACTOR + LCG_OFFSET;
            s  = {32'd0, lo};
        end else begin
            s ^= s << 11;
            s ^= s >> 13;
            s ^= s << 7;
            s  = s % XS_MODULUS;
        end
        gen_state = s;
        rem = (range_span == 31'd0) ? 64'd0 : s % {33'd0, range_span};
        return range_min + rem[31:0];
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE: gen_mode   = data[0];
            CFG_SEED: gen_state  = data;
            CFG_MIN:  range_min  = data[31:0];
            CFG_SPAN: range_span = data[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one tick and hold it until accepted; leaves valid high
    task automatic send_draw(input logic tick, input logic typed, input logic [31:0] value);
        logic [31:0] v;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            draw_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        draw_ch.valid <= 1'b1;
        draw_ch.draw  <= tick;
        do @(posedge i_clk); while (draw_ch.ready !== 1'b1);
        if (tick) begin
            v = draw_next_value();
            if (typed) v = value;
            drawn_values.insert(drawn_values.size(), v);
            n_draws++;
        end else begin
            n_ignored++;
        end
    endtask

    // Drain outstanding values, then let the block sit idle before going on
    task automatic settle();
        int waited;
        waited = 0;
        while (drawn_values.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (drawn_values.size() != 0) begin
            $error("random_value: %0d expected items never arrived", drawn_values.size());
            n_fail++;
            drawn_values.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls, one long hold-off on request, value check
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end else begin
            if (res_ch.ready === 1'b1 && $isunknown(res_ch.valid)) begin
                $error("valid: expected known level, actual %b", res_ch.valid);
                n_fail++;
            end
            if (res_ch.ready === 1'b1 && res_ch.valid === 1'b1) begin
                if (drawn_values.size() == 0) begin
                    $error("random_value: expected none waiting, actual %0d",
                           res_ch.random_value);
                    n_fail++;
                end else begin
                    want = drawn_values.pop_front();
                    n_checked++;
                    if (res_ch.random_value !== want) begin
                        $error("random_value: expected %0d, actual %0d",
                               $signed(want), res_ch.random_value);
                        n_fail++;
                    end
                end
            end
            if (hold_req && !hold_taken) begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_stim_row   row;
        logic [63:0] word;
        logic        tick;
        int          phase;
        int          n_items;
        int          sent;
        int          n_lcg_phases;
        int          n_xs_phases;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_MODE;
        i_cfg_data    = '0;
        draw_ch.valid = 1'b0;
        draw_ch.draw  = 1'b0;
        idle_on       = 1'b1;
        calm          = 1'b0;
        hold_req      = 1'b0;
        n_draws       = 0;
        n_ignored     = 0;
        n_checked     = 0;
        n_fail        = 0;
        n_lcg_phases  = 0;
        n_xs_phases   = 0;

        gen_mode   = 1'b0;
        gen_state  = 64'd6089;
        range_min  = 32'd0;
        range_span = 31'd10000;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.kind == ROW_CFG) begin
                // Registers move only once the block has gone quiet
                if (r == 0 || DIR_TABLE[r-1].kind != ROW_CFG) begin
                    draw_ch.valid <= 1'b0;
                    settle();
                end
                write_reg(row.idx, row.data);
            end else begin
                send_draw(row.tick, row.typed, row.value);
            end
        end

        phase = 0;
        while (n_draws < ITEM_TARGET) begin
            draw_ch.valid <= 1'b0;
            settle();
            calm    = (n_draws >= ITEM_TARGET - CALM_DRAWS);
            idle_on = !calm && ($urandom_range(0, 3) != 0);

            word = {$urandom(), $urandom()};
            write_reg(CFG_MODE, word);
            if (word[0]) n_xs_phases++;
            else n_lcg_phases++;

            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 4))
                    0: word = 64'd0;
                    1: word = 64'hFFFF_FFFF_FFFF_FFFF;
                    2: word = 64'($urandom_range(1, 100));
                    default: word = {$urandom(), $urandom()};
                endcase
                write_reg(CFG_SEED, word);
            end

            word = {$urandom(), $urandom()};
            case ($urandom_range(0, 5))
                0: word[31:0] = 32'h8000_0000;
                1: word[31:0] = 32'h7FFF_FFFF;
                2: word[31:0] = 32'd0;
                default: ;
            endcase
            write_reg(CFG_MIN, word);

            word = {$urandom(), $urandom()};
            case ($urandom_range(0, 9))
                0: word[30:0] = 31'd0;
                1: word[30:0] = 31'd1;
                2: word[30:0] = 31'h7FFF_FFFF;
                3: word[30:0] = 31'($urandom_range(2, 16));
                4: word[30:0] = 31'd10000;
                5, 6: word[30:0] = 31'($urandom_range(2, 1000));
                default: ;
            endcase
            write_reg(CFG_SPAN, word);

            if (phase == 1) begin
                // Long receiver hold-off while ticks keep coming: fill the block
                idle_on  = 1'b0;
                hold_req = 1'b1;
                n_items  = 80;
            end else begin
                n_items = $urandom_range(30, 150);
            end
            if (n_items > ITEM_TARGET - n_draws) n_items = ITEM_TARGET - n_draws;

            sent = 0;
            while (sent < n_items) begin
                tick = ($urandom_range(0, 11) != 0);
                send_draw(tick, 1'b0, 32'd0);
                if (tick) sent++;
            end
            phase++;
        end

        draw_ch.valid <= 1'b0;
        settle();

        $display("Run: %0d ticks drawn, %0d dropped, %0d values checked, %0d mismatches",
                 n_draws, n_ignored, n_checked, n_fail);
        $display("Random phases: %0d congruential, %0d xorshift, one long receiver hold-off",
                 n_lcg_phases, n_xs_phases);
        if (n_fail == 0) begin
            $display("dual_mode_range_prng_tb: clean");
        end else begin
            $display("dual_mode_range_prng_tb: errors");
        end
        $finish;
    end

endmodule
